// ----- rtl/cst_pkg.sv -----
// Shared types, codes and character classes of the source tokeniser.
package cst_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int FIELD_W = 24;
    localparam int MODE_W = 4;
    localparam int KIND_W = 3;
    localparam int MAX_RES = 3;
    localparam logic [FIELD_W-1:0] LINE_MAX = '1;

    localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
    localparam logic [MODE_W-1:0] M_IDENT = 4'd1;
    localparam logic [MODE_W-1:0] M_DEC   = 4'd2;
    localparam logic [MODE_W-1:0] M_ZERO  = 4'd3;
    localparam logic [MODE_W-1:0] M_HEXP  = 4'd4;
    localparam logic [MODE_W-1:0] M_HEX   = 4'd5;
    localparam logic [MODE_W-1:0] M_BINP  = 4'd6;
    localparam logic [MODE_W-1:0] M_BIN   = 4'd7;
    localparam logic [MODE_W-1:0] M_OCT   = 4'd8;
    localparam logic [MODE_W-1:0] M_REL   = 4'd9;
    localparam logic [MODE_W-1:0] M_ERR   = 4'd10;

    localparam logic [2:0] K_EOF   = 3'd0;
    localparam logic [2:0] K_IDENT = 3'd1;
    localparam logic [2:0] K_NUM   = 3'd2;
    localparam logic [2:0] K_GE    = 3'd3;
    localparam logic [2:0] K_LE    = 3'd4;
    localparam logic [2:0] K_EQ    = 3'd5;
    localparam logic [2:0] K_NE    = 3'd6;
    localparam logic [2:0] K_PUNCT = 3'd7;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_IDENT  = 3'd1;
    localparam logic [2:0] E_HEX    = 3'd2;
    localparam logic [2:0] E_BIN    = 3'd3;
    localparam logic [2:0] E_OCT    = 3'd4;
    localparam logic [2:0] E_NUM    = 3'd5;
    localparam logic [2:0] E_SYNTAX = 3'd6;

    localparam logic [1:0] R_EQ = 2'd0;
    localparam logic [1:0] R_NE = 2'd1;
    localparam logic [1:0] R_LT = 2'd2;
    localparam logic [1:0] R_GT = 2'd3;

    // Packed so that token_kind sits in the lowest bits.
    typedef struct packed {
        logic [2:0]         error_code;
        logic [FIELD_W-1:0] line_number;
        logic [FIELD_W-1:0] token_length;
        logic [FIELD_W-1:0] start_offset;
        logic [6:0]         punct_code;
        logic [KIND_W-1:0]  token_kind;
    } result_t;

    localparam int RES_W = $bits(result_t);
    // The token kind travels on its own; the remaining fields form the data word.
    localparam int RES_DATA_W = RES_W - KIND_W;
    localparam int RES_BYTES_W = ((RES_DATA_W + 7) / 8) * 8;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c >= 8'd33 && c <= 8'd126 && !is_alpha(c) && !is_digit(c);
    endfunction

    function automatic logic is_bound(input logic [7:0] c);
        return is_space(c) || is_punct(c) || c == 8'd0;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || c == "_" || is_digit(c);
    endfunction

    function automatic logic [6:0] rel_char(input logic [1:0] r);
        logic [7:0] c;
        case (r)
            R_EQ:    c = "=";
            R_NE:    c = "!";
            R_LT:    c = "<";
            default: c = ">";
        endcase
        return c[6:0];
    endfunction

    function automatic logic [2:0] rel_kind(input logic [1:0] r);
        case (r)
            R_EQ:    return K_EQ;
            R_NE:    return K_NE;
            R_LT:    return K_LE;
            default: return K_GE;
        endcase
    endfunction

endpackage

// ----- rtl/cst_lex.sv -----
// Next-state and result logic of the tokeniser for one accepted byte transaction.
module cst_lex #(
    parameter int OFFSET_BITS = cst_pkg::OFFSET_BITS_DEF
) (
    input  logic [7:0]                   source_byte,
    input  logic                         has_byte,
    input  logic                         end_of_stream,
    input  logic [cst_pkg::MODE_W-1:0]   mode_cur,
    input  logic [OFFSET_BITS-1:0]       token_start_cur,
    input  logic [cst_pkg::FIELD_W-1:0]  token_line_cur,
    input  logic [OFFSET_BITS-1:0]       byte_offset_cur,
    input  logic [cst_pkg::FIELD_W-1:0]  line_count_cur,
    input  logic [1:0]                   pend_rel_cur,
    output logic [cst_pkg::MODE_W-1:0]   mode_next,
    output logic [OFFSET_BITS-1:0]       token_start_next,
    output logic [cst_pkg::FIELD_W-1:0]  token_line_next,
    output logic [OFFSET_BITS-1:0]       byte_offset_next,
    output logic [cst_pkg::FIELD_W-1:0]  line_count_next,
    output logic [1:0]                   pend_rel_next,
    output cst_pkg::result_t             res_out [cst_pkg::MAX_RES],
    output logic [1:0]                   res_count
);
    import cst_pkg::*;

    localparam int MAXW = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    function automatic logic [FIELD_W-1:0] low24(input logic [OFFSET_BITS-1:0] v);
        logic [MAXW-1:0] t;
        t = MAXW'(v);
        return t[FIELD_W-1:0];
    endfunction

    function automatic result_t mk(input logic [2:0] kind, input logic [6:0] pc,
                                   input logic [OFFSET_BITS-1:0] start,
                                   input logic [OFFSET_BITS-1:0] len,
                                   input logic [FIELD_W-1:0] line, input logic [2:0] err);
        result_t r;
        r.token_kind   = kind;
        r.punct_code   = pc;
        r.start_offset = low24(start);
        r.token_length = low24(len);
        r.line_number  = line;
        r.error_code   = err;
        return r;
    endfunction

    always_comb begin
        logic [MODE_W-1:0]      m;
        logic [OFFSET_BITS-1:0] start_v;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] end_v;
        logic [FIELD_W-1:0]     tline_v;
        logic [FIELD_W-1:0]     line_v;
        logic [1:0]             pr;
        logic [7:0]             c;
        logic                   go_idle;
        logic [3:0]             ev;
        result_t                er [4];
        logic [1:0]             cnt;

        m       = mode_cur;
        start_v = token_start_cur;
        tline_v = token_line_cur;
        pos     = byte_offset_cur;
        line_v  = line_count_cur;
        pr      = pend_rel_cur;
        c       = source_byte;
        go_idle = 1'b0;
        ev      = '0;
        for (int i = 0; i < 4; i++) begin
            er[i] = '0;
        end

        // A byte first closes or extends the open token; a token closed on a
        // boundary byte hands that byte back to the idle decode.
        if (has_byte && m != M_ERR) begin
            case (m)
                M_IDLE: begin
                    go_idle = 1'b1;
                end
                M_IDENT: begin
                    if (!is_word(c)) begin
                        ev[0] = 1'b1;
                        if (is_bound(c)) begin
                            er[0] = mk(K_IDENT, 7'd0, start_v, pos - start_v, tline_v, E_NONE);
                            go_idle = 1'b1;
                        end else begin
                            er[0] = mk(K_EOF, 7'd0, pos, '0, line_v, E_IDENT);
                            m = M_ERR;
                        end
                    end
                end
                M_DEC, M_HEX, M_BIN, M_OCT: begin
                    logic stay;
                    logic [2:0] ecode;
                    case (m)
                        M_DEC: begin
                            stay  = is_digit(c);
                            ecode = E_NUM;
                        end
                        M_HEX: begin
                            stay  = is_xdigit(c);
                            ecode = E_HEX;
                        end
                        M_BIN: begin
                            stay  = (c == "0" || c == "1");
                            ecode = E_BIN;
                        end
                        default: begin
                            stay  = (c >= "0" && c <= "7");
                            ecode = E_OCT;
                        end
                    endcase
                    if (!stay) begin
                        ev[0] = 1'b1;
                        if (is_bound(c)) begin
                            er[0] = mk(K_NUM, 7'd0, start_v, pos - start_v, tline_v, E_NONE);
                            go_idle = 1'b1;
                        end else begin
                            er[0] = mk(K_EOF, 7'd0, pos, '0, line_v, ecode);
                            m = M_ERR;
                        end
                    end
                end
                M_ZERO: begin
                    if (is_bound(c)) begin
                        ev[0] = 1'b1;
                        er[0] = mk(K_NUM, 7'd0, start_v, pos - start_v, tline_v, E_NONE);
                        go_idle = 1'b1;
                    end else if (c == "x" || c == "X") begin
                        m = M_HEXP;
                    end else if (c == "b" || c == "B") begin
                        m = M_BINP;
                    end else if (c >= "0" && c <= "7") begin
                        m = M_OCT;
                    end else begin
                        ev[0] = 1'b1;
                        er[0] = mk(K_EOF, 7'd0, pos, '0, line_v, E_NUM);
                        m = M_ERR;
                    end
                end
                M_HEXP: begin
                    if (is_xdigit(c)) begin
                        m = M_HEX;
                    end else begin
                        ev[0] = 1'b1;
                        er[0] = mk(K_EOF, 7'd0, pos, '0, line_v, E_HEX);
                        m = M_ERR;
                    end
                end
                M_BINP: begin
                    if (c == "0" || c == "1") begin
                        m = M_BIN;
                    end else begin
                        ev[0] = 1'b1;
                        er[0] = mk(K_EOF, 7'd0, pos, '0, line_v, E_BIN);
                        m = M_ERR;
                    end
                end
                M_REL: begin
                    ev[0] = 1'b1;
                    if (c == "=") begin
                        er[0] = mk(rel_kind(pr), 7'd0, start_v, OFFSET_BITS'(2), tline_v,
                                   E_NONE);
                        m = M_IDLE;
                    end else begin
                        er[0] = mk(K_PUNCT, rel_char(pr), start_v, OFFSET_BITS'(1), tline_v,
                                   E_NONE);
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    m = M_ERR;
                end
            endcase

            if (go_idle) begin
                m = M_IDLE;
                if (is_space(c)) begin
                    if (c == 8'd10 && line_v != LINE_MAX) begin
                        line_v = line_v + 1'b1;
                    end
                end else begin
                    start_v = pos;
                    tline_v = line_v;
                    if (is_alpha(c) || c == "_") begin
                        m = M_IDENT;
                    end else if (is_digit(c)) begin
                        m = (c == "0") ? M_ZERO : M_DEC;
                    end else if (c == "=") begin
                        pr = R_EQ;
                        m  = M_REL;
                    end else if (c == "!") begin
                        pr = R_NE;
                        m  = M_REL;
                    end else if (c == "<") begin
                        pr = R_LT;
                        m  = M_REL;
                    end else if (c == ">") begin
                        pr = R_GT;
                        m  = M_REL;
                    end else if (is_punct(c)) begin
                        ev[1] = 1'b1;
                        er[1] = mk(K_PUNCT, c[6:0], pos, OFFSET_BITS'(1), line_v, E_NONE);
                    end else begin
                        ev[1] = 1'b1;
                        er[1] = mk(K_EOF, 7'd0, pos, '0, line_v, E_SYNTAX);
                        m = M_ERR;
                    end
                end
            end
        end

        end_v = byte_offset_cur;
        if (has_byte && byte_offset_cur != OFF_MAX) begin
            end_v = byte_offset_cur + 1'b1;
        end

        // End of stream: flush the open token, then the end-of-file token.
        if (end_of_stream && m != M_ERR) begin
            case (m)
                M_IDENT: begin
                    ev[2] = 1'b1;
                    er[2] = mk(K_IDENT, 7'd0, start_v, end_v - start_v, tline_v, E_NONE);
                end
                M_DEC, M_ZERO, M_HEX, M_BIN, M_OCT: begin
                    ev[2] = 1'b1;
                    er[2] = mk(K_NUM, 7'd0, start_v, end_v - start_v, tline_v, E_NONE);
                end
                M_HEXP: begin
                    ev[2] = 1'b1;
                    er[2] = mk(K_EOF, 7'd0, end_v, '0, line_v, E_HEX);
                    m = M_ERR;
                end
                M_BINP: begin
                    ev[2] = 1'b1;
                    er[2] = mk(K_EOF, 7'd0, end_v, '0, line_v, E_BIN);
                    m = M_ERR;
                end
                M_REL: begin
                    ev[2] = 1'b1;
                    er[2] = mk(K_PUNCT, rel_char(pr), start_v, OFFSET_BITS'(1), tline_v,
                               E_NONE);
                end
                default: begin
                end
            endcase
            if (m != M_ERR) begin
                ev[3] = 1'b1;
                er[3] = mk(K_EOF, 7'd0, end_v, '0, line_v, E_NONE);
            end
        end

        if (end_of_stream) begin
            m       = M_IDLE;
            start_v = '0;
            tline_v = FIELD_W'(1);
            end_v   = '0;
            line_v  = FIELD_W'(1);
            pr      = R_EQ;
        end

        mode_next        = m;
        token_start_next = start_v;
        token_line_next  = tline_v;
        byte_offset_next = end_v;
        line_count_next  = line_v;
        pend_rel_next    = pr;

        // Pack the candidates in order; at most three survive.
        cnt = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_out[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (ev[i] && cnt != 2'd3) begin
                res_out[cnt] = er[i];
                cnt = cnt + 1'b1;
            end
        end
        res_count = cnt;
    end

endmodule

// ----- rtl/c_source_tokenizer_core.sv -----
// Top level of the source tokeniser: state registers and the result queue.
//
// Source bytes enter on the s_ channel, one per transaction: s_tdata carries
// the byte, s_tuser says whether the byte is valid, and s_tlast marks the
// final transaction of a stream. Tokens leave on the m_ channel, one per
// transaction: m_tuser carries the token kind, m_tdata the other fields, and
// m_tlast is set on the final token caused by an input transaction. Each
// input transaction yields from none to three tokens; they are written
// together into a four-entry result queue in the same cycle.
// A token is presented once the tokens queued ahead of it have been taken.
// s_tready is high while the queue holds at most one token, so an input
// transaction can be taken every cycle as long as each yields at most one
// token and the receiver takes a token every cycle; every token beyond the
// first from one transaction keeps s_tready low until the queue is back to
// one token. A stalled receiver fills the queue and then holds s_tready low.
// The end-of-stream transaction returns the lexer state to its reset values.
// Reset empties the queue and starts a new stream at offset 0, line 1.
module c_source_tokenizer_core #(
    parameter int OFFSET_BITS = cst_pkg::OFFSET_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // source_byte
    input  logic [0:0]                      s_tuser,  // has_byte
    input  logic                            s_tlast,  // end_of_stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // punct_code, start_offset, token_length, line_number, error_code,
    // then zero fill
    output logic [cst_pkg::RES_BYTES_W-1:0] m_tdata,
    output logic [cst_pkg::KIND_W-1:0]      m_tuser,  // token_kind
    output logic                            m_tlast   // last_result
);
    import cst_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] token_start_reg, token_start_next;
    logic [FIELD_W-1:0]     token_line_reg, token_line_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [FIELD_W-1:0]     line_count_reg, line_count_next;
    logic [1:0]             pend_rel_reg, pend_rel_next;

    result_t                res [MAX_RES];
    logic [1:0]             res_count;

    result_t                q_data_reg [QDEPTH];
    logic                   q_last_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]        q_count_reg, q_count_next;
    result_t                q_head;

    logic                   s_accept;
    logic                   m_accept;

    cst_lex #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lex (
        .source_byte      (s_tdata),
        .has_byte         (s_tuser[0]),
        .end_of_stream    (s_tlast),
        .mode_cur         (mode_reg),
        .token_start_cur  (token_start_reg),
        .token_line_cur   (token_line_reg),
        .byte_offset_cur  (byte_offset_reg),
        .line_count_cur   (line_count_reg),
        .pend_rel_cur     (pend_rel_reg),
        .mode_next        (mode_next),
        .token_start_next (token_start_next),
        .token_line_next  (token_line_next),
        .byte_offset_next (byte_offset_next),
        .line_count_next  (line_count_next),
        .pend_rel_next    (pend_rel_next),
        .res_out          (res),
        .res_count        (res_count)
    );

    // Room for the worst case of three tokens from one transaction.
    assign s_tready = q_count_reg <= (QPTR_W+1)'(QDEPTH - MAX_RES);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = q_count_reg != '0;
    assign m_accept = m_tvalid && m_tready;
    assign q_head   = q_data_reg[rd_ptr_reg];
    assign m_tuser  = q_head.token_kind;
    assign m_tdata  = RES_BYTES_W'(q_head[RES_W-1:KIND_W]);
    assign m_tlast  = q_last_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_count_next = q_count_reg;
        if (s_accept) begin
            wr_ptr_next  = wr_ptr_reg + QPTR_W'(res_count);
            q_count_next = q_count_next + (QPTR_W+1)'(res_count);
        end
        if (m_accept) begin
            rd_ptr_next  = rd_ptr_reg + 1'b1;
            q_count_next = q_count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= M_IDLE;
            token_start_reg <= '0;
            token_line_reg  <= FIELD_W'(1);
            byte_offset_reg <= '0;
            line_count_reg  <= FIELD_W'(1);
            pend_rel_reg    <= R_EQ;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            q_count_reg     <= '0;
        end else begin
            if (s_accept) begin
                mode_reg        <= mode_next;
                token_start_reg <= token_start_next;
                token_line_reg  <= token_line_next;
                byte_offset_reg <= byte_offset_next;
                line_count_reg  <= line_count_next;
                pend_rel_reg    <= pend_rel_next;
            end
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (2'(i) < res_count) begin
                    q_data_reg[wr_ptr_reg + QPTR_W'(i)] <= res[i];
                    q_last_reg[wr_ptr_reg + QPTR_W'(i)] <= (2'(i) == res_count - 1'b1);
                end
            end
        end
    end

endmodule
